// File: rtl/dmac_pkg.sv
// Shared types and constants for the four-channel DMA controller.
`default_nettype none
package dmac_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int CH_W = $clog2(NUM_CHANNELS);

  // item opcodes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_DMA   = 2'd2;

  // memory direction codes on mem_op
  localparam logic [1:0] MOP_NONE  = 2'd0;
  localparam logic [1:0] MOP_WRITE = 2'd1;
  localparam logic [1:0] MOP_READ  = 2'd2;

  // direction field in the top two count bits
  localparam logic [1:0] DIR_WRITE = 2'd1;
  localparam logic [1:0] DIR_READ  = 2'd2;

  localparam logic [3:0]  MODE_REG_ADDR = 4'd8;
  localparam logic [13:0] CNT_ALL_ONES  = 14'h3fff;
  localparam logic [7:0]  RD_UNMAPPED   = 8'hff;
  localparam int          AUTOLOAD_BIT  = 7;
  localparam int          TC_STOP_BIT   = 6;
  localparam logic [CH_W-1:0] AUTOLOAD_SRC = CH_W'(2);
  localparam logic [CH_W-1:0] AUTOLOAD_DST = CH_W'(3);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } ctrl_state_t;

  typedef struct packed {
    logic load;  // capture the accepted word
    logic exec;  // apply it and load the output register
  } dp_cmd_t;

endpackage
`default_nettype wire

// File: rtl/dmac_ctrl.sv
// Controller: sequences one word at a time and owns the output valid flag.
`default_nettype none
module dmac_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output dmac_pkg::dp_cmd_t      cmd
);
  import dmac_pkg::*;

  ctrl_state_t state, state_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    cmd.load       = 1'b0;
    cmd.exec       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // wait here only while an earlier result still sits unclaimed
        if (!out_valid || out_ready) begin
          cmd.exec       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/dmac_datapath.sv
// Datapath: channel registers, mode/status, byte flip-flop and result register.
`default_nettype none
module dmac_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dmac_pkg::dp_cmd_t cmd,
  input  wire logic [1:0]        mode,
  input  wire logic [3:0]        reg_addr,
  input  wire logic [7:0]        wdata,
  input  wire logic [1:0]        channel,
  input  wire logic              swap_rw_we,
  input  wire logic              swap_rw,
  output logic [7:0]             rdata,
  output logic                   granted,
  output logic [15:0]            mem_addr,
  output logic [1:0]             mem_op,
  output logic                   terminal_count
);
  import dmac_pkg::*;

  function automatic logic [15:0] put_byte(input logic [15:0] r, input logic [7:0] b,
                                           input logic low);
    put_byte = low ? {r[15:8], b} : {b, r[7:0]};
  endfunction

  // architectural state
  logic [15:0] chan_address [NUM_CHANNELS];
  logic [15:0] chan_count   [NUM_CHANNELS];
  logic [7:0]  mode_bits;
  logic [7:0]  status_bits;
  logic        low_byte_next;
  logic        swap_q;

  // captured word
  logic [1:0]      op_q;
  logic [3:0]      addr_q;
  logic [7:0]      wdata_q;
  logic [CH_W-1:0] ch_q;

  logic [15:0] chan_address_next [NUM_CHANNELS];
  logic [15:0] chan_count_next   [NUM_CHANNELS];
  logic [7:0]  mode_bits_next;
  logic [7:0]  status_bits_next;
  logic        low_byte_next_next;
  logic [7:0]  rdata_next;
  logic        granted_next;
  logic [15:0] mem_addr_next;
  logic [1:0]  mem_op_next;
  logic        tc_next;

  logic [CH_W-1:0]         reg_ch;
  logic                    autoload;
  logic                    mirror;
  logic                    reload;
  logic [15:0]             src_addr;
  logic [15:0]             src_cnt;
  logic [13:0]             cnt_dec;
  logic                    hit_tc;
  logic [15:0]             rd_sel;
  logic [NUM_CHANNELS-1:0] ch_onehot;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= mode;
      addr_q  <= reg_addr;
      wdata_q <= wdata;
      ch_q    <= channel;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rdata          <= rdata_next;
      granted        <= granted_next;
      mem_addr       <= mem_addr_next;
      mem_op         <= mem_op_next;
      terminal_count <= tc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        chan_address[i] <= '0;
        chan_count[i]   <= '0;
      end
      mode_bits     <= '0;
      status_bits   <= '0;
      low_byte_next <= 1'b1;
      swap_q        <= 1'b0;
    end else begin
      if (swap_rw_we) begin
        swap_q <= swap_rw;
      end
      if (cmd.exec) begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          chan_address[i] <= chan_address_next[i];
          chan_count[i]   <= chan_count_next[i];
        end
        mode_bits     <= mode_bits_next;
        status_bits   <= status_bits_next;
        low_byte_next <= low_byte_next_next;
      end
    end
  end

  always_comb begin
    reg_ch    = addr_q[CH_W:1];
    autoload  = mode_bits[AUTOLOAD_BIT];
    mirror    = autoload && (reg_ch == AUTOLOAD_SRC);
    ch_onehot = NUM_CHANNELS'(1) << ch_q;

    // channel 2 reloads from channel 3 before counting on autoload
    reload   = autoload && (ch_q == AUTOLOAD_SRC) &&
               (chan_count[AUTOLOAD_SRC][13:0] == CNT_ALL_ONES);
    src_addr = reload ? chan_address[AUTOLOAD_DST] : chan_address[ch_q];
    src_cnt  = reload ? chan_count[AUTOLOAD_DST]   : chan_count[ch_q];
    cnt_dec  = src_cnt[13:0] - 14'd1;
    hit_tc   = (cnt_dec == CNT_ALL_ONES);

    rd_sel = addr_q[0] ? chan_count[reg_ch] : chan_address[reg_ch];

    for (int i = 0; i < NUM_CHANNELS; i++) begin
      chan_address_next[i] = chan_address[i];
      chan_count_next[i]   = chan_count[i];
    end
    mode_bits_next     = mode_bits;
    status_bits_next   = status_bits;
    low_byte_next_next = low_byte_next;
    rdata_next         = '0;
    granted_next       = 1'b0;
    mem_addr_next      = '0;
    mem_op_next        = MOP_NONE;
    tc_next            = 1'b0;

    case (op_q)
      OP_WRITE: begin
        if (addr_q == MODE_REG_ADDR) begin
          mode_bits_next     = wdata_q;
          low_byte_next_next = 1'b1;
        end else if (!addr_q[3]) begin
          for (int i = 0; i < NUM_CHANNELS; i++) begin
            if ((CH_W'(i) == reg_ch) || ((CH_W'(i) == AUTOLOAD_DST) && mirror)) begin
              if (addr_q[0]) begin
                chan_count_next[i] = put_byte(chan_count[i], wdata_q, low_byte_next);
              end else begin
                chan_address_next[i] = put_byte(chan_address[i], wdata_q, low_byte_next);
              end
            end
          end
          low_byte_next_next = !low_byte_next;
        end
      end
      OP_READ: begin
        if (addr_q == MODE_REG_ADDR) begin
          rdata_next       = status_bits;
          status_bits_next = {status_bits[7:NUM_CHANNELS], {NUM_CHANNELS{1'b0}}};
        end else if (!addr_q[3]) begin
          rdata_next         = low_byte_next ? rd_sel[7:0] : rd_sel[15:8];
          low_byte_next_next = !low_byte_next;
        end else begin
          rdata_next = RD_UNMAPPED;
        end
      end
      OP_DMA: begin
        if (mode_bits[ch_q]) begin
          granted_next            = 1'b1;
          mem_addr_next           = src_addr;
          chan_address_next[ch_q] = src_addr + 16'd1;
          chan_count_next[ch_q]   = {src_cnt[15:14], cnt_dec};
          case (src_cnt[15:14])
            DIR_WRITE: mem_op_next = swap_q ? MOP_READ : MOP_WRITE;
            DIR_READ:  mem_op_next = swap_q ? MOP_WRITE : MOP_READ;
            default:   mem_op_next = MOP_NONE;
          endcase
          if (hit_tc) begin
            tc_next = 1'b1;
            status_bits_next[NUM_CHANNELS-1:0] = status_bits[NUM_CHANNELS-1:0] | ch_onehot;
            if (mode_bits[TC_STOP_BIT] && !(autoload && (ch_q == AUTOLOAD_SRC))) begin
              mode_bits_next[NUM_CHANNELS-1:0] = mode_bits[NUM_CHANNELS-1:0] & ~ch_onehot;
            end
          end
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/four_channel_dma_controller.sv
// Top level of the four-channel DMA controller: controller plus datapath.
//
//   channel   signals                                   handshake
//   input     mode, reg_addr, wdata, channel            in_valid / in_ready
//   output    rdata, granted, mem_addr, mem_op,         out_valid / out_ready
//             terminal_count
//   config    swap_rw                                   swap_rw_we, no wait
//
// Each word is captured in the idle state; the execute state then updates the
// channel registers and loads the output register; idle then takes the next word.
// The execute cycle holds only while the output register is still full.
// rst is synchronous: channel registers, mode and status clear, the byte
// flip-flop points at the low byte, swap_rw clears.
`default_nettype none
module four_channel_dma_controller (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic [3:0]  reg_addr,
  input  wire logic [7:0]  wdata,
  input  wire logic [1:0]  channel,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       rdata,
  output logic             granted,
  output logic [15:0]      mem_addr,
  output logic [1:0]       mem_op,
  output logic             terminal_count,
  input  wire logic        swap_rw_we,
  input  wire logic        swap_rw
);
  import dmac_pkg::*;

  dp_cmd_t cmd;

  dmac_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  dmac_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .mode           (mode),
    .reg_addr       (reg_addr),
    .wdata          (wdata),
    .channel        (channel),
    .swap_rw_we     (swap_rw_we),
    .swap_rw        (swap_rw),
    .rdata          (rdata),
    .granted        (granted),
    .mem_addr       (mem_addr),
    .mem_op         (mem_op),
    .terminal_count (terminal_count)
  );

  // one word in flight: no accept in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("word accepted while previous one still executing");

  a_tc_needs_grant: assert property (@(posedge clk) disable iff (rst)
    (out_valid && terminal_count) |-> granted)
    else $error("terminal count flagged on a word that was not granted");

  a_idle_transfer: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !granted) |-> (mem_op == MOP_NONE && mem_addr == 16'd0))
    else $error("memory cycle reported without a grant");

  a_grant_no_rdata: assert property (@(posedge clk) disable iff (rst)
    (out_valid && granted) |-> (rdata == 8'd0))
    else $error("read data on a DMA transfer word");

endmodule
`default_nettype wire
